FILE: hw/rtl/chi_pkg.sv
package chi_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam logic [7:0] TOL_RESET = 8'd1;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_ROT  = 2'd1;
  localparam logic [1:0] CELL_INS  = 2'd2;
  localparam logic [1:0] CELL_SEED = 2'd3;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [15:0] hull_x;
    logic signed [15:0] hull_y;
    logic [5:0]         vertex_index;
    logic               last_vertex;
  } hull_t;

  typedef struct packed {
    logic [1:0] op;
    logic       at_first;
    logic       at_ins;
    logic       past_ins;
    logic       at_end;
  } cell_ctl_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic pt_v;
  } edge_cmd_t;

  typedef struct packed {
    logic idle;
    logic found;
  } edge_sts_t;

endpackage

FILE: hw/rtl/chi_hull_cell.sv
module chi_hull_cell #(
  parameter int IW = 5
) (
  input  logic              clk,
  input  chi_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]     head_i,
  input  logic [IW-1:0]     prev_i,
  input  logic [IW-1:0]     next_i,
  input  logic [IW-1:0]     new_i,
  input  logic [IW-1:0]     seed_a_i,
  input  logic [IW-1:0]     seed_b_i,
  output logic [IW-1:0]     idx_o
);

  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_nxt;

  always_comb begin
    idx_nxt = idx_r;
    case (ctl.op)
      chi_pkg::CELL_ROT: begin
        idx_nxt = ctl.at_end ? head_i : next_i;
      end
      chi_pkg::CELL_INS: begin
        if (ctl.at_ins) begin
          idx_nxt = new_i;
        end else if (ctl.past_ins) begin
          idx_nxt = prev_i;
        end
      end
      chi_pkg::CELL_SEED: begin
        if (ctl.at_first) begin
          idx_nxt = seed_a_i;
        end else if (ctl.at_ins) begin
          idx_nxt = seed_b_i;
        end
      end
      default: idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign idx_o = idx_r;

endmodule

FILE: hw/rtl/chi_edge_unit.sv
module chi_edge_unit #(
  parameter int IW = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  chi_pkg::edge_cmd_t cmd,
  input  logic signed [15:0] pt_x,
  input  logic signed [15:0] pt_y,
  input  logic [IW-1:0]      pt_idx,
  input  logic [7:0]         tol,
  output chi_pkg::edge_sts_t sts,
  output logic [IW-1:0]      best_idx
);

  logic signed [15:0] ax_r, ay_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0]        dxx_r, dyy_r;
  logic [15:0]        tt_r;
  logic [34:0]        dl_r;
  logic [50:0]        lim_r;
  logic               su1_r, su2_r, su3_r;

  logic               pv1_r, pv2_r, pv3_r, pv4_r;
  logic [IW-1:0]      idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [16:0] vx1_r, vy1_r;
  logic signed [33:0] m1_r, m2_r;
  logic signed [34:0] c3_r, c4_r;
  logic               neg4_r, big4_r;
  logic [49:0]        sq4_r;
  logic [34:0]        mag;

  logic               found_r;
  logic signed [34:0] most_r;
  logic [IW-1:0]      best_r;
  logic               beyond;

  assign mag    = 35'(-c3_r);
  assign beyond = neg4_r && (big4_r || (51'(sq4_r) > lim_r));

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      ax_r <= pt_x;
      ay_r <= pt_y;
    end
    if (cmd.ld_b) begin
      dx_r <= 17'(pt_x) - 17'(ax_r);
      dy_r <= 17'(pt_y) - 17'(ay_r);
    end
    dxx_r <= 34'(dx_r * dx_r);
    dyy_r <= 34'(dy_r * dy_r);
    tt_r  <= 16'(tol) * 16'(tol);
    dl_r  <= 35'(dxx_r) + 35'(dyy_r);
    lim_r <= 51'(tt_r) * 51'(dl_r);

    idx1_r <= pt_idx;
    vx1_r  <= 17'(pt_x) - 17'(ax_r);
    vy1_r  <= 17'(pt_y) - 17'(ay_r);
    idx2_r <= idx1_r;
    m1_r   <= 34'(dx_r * vy1_r);
    m2_r   <= 34'(dy_r * vx1_r);
    idx3_r <= idx2_r;
    c3_r   <= 35'(m1_r) - 35'(m2_r);
    idx4_r <= idx3_r;
    c4_r   <= c3_r;
    neg4_r <= c3_r[34];
    big4_r <= |mag[34:25];
    sq4_r  <= 50'(mag[24:0]) * 50'(mag[24:0]);
    if (pv4_r && beyond && (!found_r || c4_r < most_r)) begin
      most_r <= c4_r;
      best_r <= idx4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su1_r   <= 1'b0;
      su2_r   <= 1'b0;
      su3_r   <= 1'b0;
      pv1_r   <= 1'b0;
      pv2_r   <= 1'b0;
      pv3_r   <= 1'b0;
      pv4_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      su1_r <= cmd.ld_b;
      su2_r <= su1_r;
      su3_r <= su2_r;
      pv1_r <= cmd.pt_v;
      pv2_r <= pv1_r;
      pv3_r <= pv2_r;
      pv4_r <= pv3_r;
      if (cmd.ld_b) begin
        found_r <= 1'b0;
      end else if (pv4_r && beyond) begin
        found_r <= 1'b1;
      end
    end
  end

  assign sts.idle  = !(su1_r || su2_r || su3_r || pv1_r || pv2_r || pv3_r || pv4_r);
  assign sts.found = found_r;
  assign best_idx  = best_r;

  hull_x_unused_chk : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pt_v |-> !(su1_r || su2_r || su3_r))
    else $error("point fed during edge setup");

endmodule

FILE: hw/rtl/convex_hull_insertion.sv
// channel  dir  handshake             payload
// in_      in   in_valid / in_stall   chi_pkg::point_t
// out_     out  out_valid / out_stall chi_pkg::hull_t
// cfg_     in   cfg_wr_en             edge_tolerance, 8 bits
// points load at one per cycle; the point with last_point set starts the hull search
// search: an extreme scan and seed, then per edge one pass over all stored points
// (one store read port, one point per cycle through the edge unit) plus list rotations
// each vertex leaves through a single output register; the next is read only after that transfer
// no input is taken from the last point until the final vertex transfer
// reset clears control and sets the tolerance to one
module convex_hull_insertion #(
  parameter int MAX_POINTS = chi_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  chi_pkg::point_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output chi_pkg::hull_t   out_data,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);

  localparam int CAP = MAX_POINTS + 1;
  localparam int IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int LW  = $clog2(MAX_POINTS + 2);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_MM     = 4'd1;
  localparam logic [3:0] S_MM_END = 4'd2;
  localparam logic [3:0] S_SEED   = 4'd3;
  localparam logic [3:0] S_E_RA   = 4'd4;
  localparam logic [3:0] S_E_RB   = 4'd5;
  localparam logic [3:0] S_E_LB   = 4'd6;
  localparam logic [3:0] S_SETUP  = 4'd7;
  localparam logic [3:0] S_FEED   = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;
  localparam logic [3:0] S_DECIDE = 4'd10;
  localparam logic [3:0] S_REWIND = 4'd11;
  localparam logic [3:0] S_EM_RD  = 4'd12;
  localparam logic [3:0] S_EM_LD  = 4'd13;
  localparam logic [3:0] S_EM_WT  = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    tol_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] rot_r, rot_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic          fv_r, fv_nxt;
  logic [IW-1:0] idx_d_r;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_r;
  logic [31:0]   store [MAX_POINTS];
  logic [IW-1:0] left_r, right_r;
  logic signed [15:0] lx_r, rx_r;
  logic          out_valid_r, out_valid_nxt;
  chi_pkg::hull_t out_data_r;
  logic [1:0]    cell_op;
  logic [IW-1:0] cell_idx [CAP];
  logic          in_xfer, out_xfer;
  logic          rot_wrap;

  chi_pkg::edge_cmd_t ecmd;
  chi_pkg::edge_sts_t ests;
  logic [IW-1:0]      best_idx;
  logic signed [15:0] rd_x, rd_y;

  assign in_stall  = (state_r != S_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_x      = rd_r[15:0];
  assign rd_y      = rd_r[31:16];
  assign rot_wrap  = (rot_r + LW'(1) == len_r);

  always_ff @(posedge clk) begin
    if (in_xfer && (cnt_r < CW'(MAX_POINTS))) begin
      store[cnt_r[IW-1:0]] <= {in_data.point_y, in_data.point_x};
    end
    rd_r <= store[rd_addr];
  end

  always_comb begin
    case (state_r)
      S_E_RA, S_EM_RD: rd_addr = cell_idx[0];
      S_E_RB:          rd_addr = cell_idx[1];
      default:         rd_addr = i_r[IW-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    len_nxt       = len_r;
    rot_nxt       = rot_r;
    k_nxt         = k_r;
    fv_nxt        = 1'b0;
    out_valid_nxt = out_valid_r;
    cell_op       = chi_pkg::CELL_HOLD;
    ecmd          = '0;
    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_data.last_point) begin
            i_nxt     = '0;
            state_nxt = S_MM;
          end
        end
      end
      S_MM: begin
        fv_nxt = 1'b1;
        i_nxt  = i_r + CW'(1);
        if (i_r + CW'(1) >= cnt_r) begin
          state_nxt = S_MM_END;
        end
      end
      S_MM_END: state_nxt = S_SEED;
      S_SEED: begin
        cell_op   = chi_pkg::CELL_SEED;
        len_nxt   = LW'(2);
        rot_nxt   = '0;
        state_nxt = S_E_RA;
      end
      S_E_RA: begin
        if (len_r == LW'(CAP)) begin
          cell_op = chi_pkg::CELL_ROT;
          if (rot_wrap) begin
            k_nxt     = '0;
            state_nxt = S_EM_RD;
          end else begin
            rot_nxt = rot_r + LW'(1);
          end
        end else begin
          state_nxt = S_E_RB;
        end
      end
      S_E_RB: begin
        ecmd.ld_a = 1'b1;
        state_nxt = S_E_LB;
      end
      S_E_LB: begin
        ecmd.ld_b = 1'b1;
        i_nxt     = '0;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        if (ests.idle) begin
          state_nxt = S_FEED;
        end
      end
      S_FEED: begin
        ecmd.pt_v = fv_r;
        fv_nxt    = 1'b1;
        i_nxt     = i_r + CW'(1);
        if (i_r + CW'(1) >= cnt_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ecmd.pt_v = fv_r;
        if (ests.idle && !fv_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (ests.found) begin
          cell_op = chi_pkg::CELL_INS;
          len_nxt = len_r + LW'(1);
          if (rot_wrap) begin
            rot_nxt = len_r;
          end
          state_nxt = S_REWIND;
        end else begin
          cell_op = chi_pkg::CELL_ROT;
          if (rot_wrap) begin
            k_nxt     = '0;
            state_nxt = S_EM_RD;
          end else begin
            rot_nxt   = rot_r + LW'(1);
            state_nxt = S_E_RA;
          end
        end
      end
      S_REWIND: begin
        if (rot_r == '0) begin
          state_nxt = S_E_RA;
        end else begin
          cell_op = chi_pkg::CELL_ROT;
          rot_nxt = rot_wrap ? '0 : rot_r + LW'(1);
        end
      end
      S_EM_RD: state_nxt = S_EM_LD;
      S_EM_LD: begin
        cell_op       = chi_pkg::CELL_ROT;
        out_valid_nxt = 1'b1;
        k_nxt         = k_r + LW'(1);
        state_nxt     = S_EM_WT;
      end
      S_EM_WT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.last_vertex) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      tol_r       <= chi_pkg::TOL_RESET;
      cnt_r       <= '0;
      len_r       <= '0;
      rot_r       <= '0;
      k_r         <= '0;
      i_r         <= '0;
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      rot_r       <= rot_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= i_r[IW-1:0];
    if (fv_r && (state_r == S_MM || state_r == S_MM_END)) begin
      if (idx_d_r == '0 || rd_x < lx_r) begin
        left_r <= idx_d_r;
        lx_r   <= rd_x;
      end
      if (idx_d_r == '0 || rd_x > rx_r) begin
        right_r <= idx_d_r;
        rx_r    <= rd_x;
      end
    end
    if (state_r == S_EM_LD) begin
      out_data_r.hull_x       <= rd_x;
      out_data_r.hull_y       <= rd_y;
      out_data_r.vertex_index <= 6'(k_r);
      out_data_r.last_vertex  <= (k_r + LW'(1) == len_r);
    end
  end

  // hull list, one vertex index per cell
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    chi_pkg::cell_ctl_t ctl;
    logic [IW-1:0]      prev_v, next_v;
    assign ctl.op       = cell_op;
    assign ctl.at_first = (g == 0);
    assign ctl.at_ins   = (g == 1);
    assign ctl.past_ins = (g > 1);
    assign ctl.at_end   = (LW'(g) + LW'(1) == len_r);
    assign prev_v       = cell_idx[(g > 0) ? g - 1 : 0];
    assign next_v       = cell_idx[(g < CAP - 1) ? g + 1 : g];

    chi_hull_cell #(.IW(IW)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .head_i   (cell_idx[0]),
      .prev_i   (prev_v),
      .next_i   (next_v),
      .new_i    (best_idx),
      .seed_a_i (left_r),
      .seed_b_i (right_r),
      .idx_o    (cell_idx[g])
    );
  end

  chi_edge_unit #(.IW(IW)) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ecmd),
    .pt_x     (rd_x),
    .pt_y     (rd_y),
    .pt_idx   (idx_d_r),
    .tol      (tol_r),
    .sts      (ests),
    .best_idx (best_idx)
  );

  len_cap_chk : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAP))
    else $error("hull list beyond capacity");

  out_state_chk : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EM_WT))
    else $error("vertex shown outside emission");

  ins_room_chk : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && ests.found) |-> (len_r < LW'(CAP)))
    else $error("insertion into full hull list");

  rot_range_chk : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E_RA) |-> (rot_r < len_r))
    else $error("list rotation out of range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NPTS     = chi_pkg::MAX_POINTS_DEF;
  localparam int LIST_CAP = NPTS + 1;
  localparam int LIMIT    = 3000000;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  chi_pkg::point_t in_data;
  logic            out_valid;
  logic            out_stall;
  chi_pkg::hull_t  out_data;
  logic            cfg_wr_en;
  logic [7:0]      cfg_wr_data;

  convex_hull_insertion #(.MAX_POINTS(NPTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic signed [15:0] set_x [NPTS];
  logic signed [15:0] set_y [NPTS];
  int                 set_count;
  logic [7:0]         tolerance;
  int                 order [LIST_CAP];
  int                 order_len;
  chi_pkg::hull_t     pending_vertices [$];

  int  errors;
  int  cycles;
  int  burst_left;
  int  hold_req;
  int  hold_cnt;
  bit  calm_phase;
  int  items_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt = hold_cnt - 1;
    end else begin
      if ($urandom_range(0, 63) == 0) calm_phase = ~calm_phase;
      out_stall <= calm_phase ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    chi_pkg::hull_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected transfer x=%0d y=%0d", out_data.hull_x, out_data.hull_y);
        errors++;
      end else begin
        want = pending_vertices.pop_front();
        if (out_data.hull_x !== want.hull_x) begin
          $error("hull_x expected %0d actual %0d", want.hull_x, out_data.hull_x);
          errors++;
        end
        if (out_data.hull_y !== want.hull_y) begin
          $error("hull_y expected %0d actual %0d", want.hull_y, out_data.hull_y);
          errors++;
        end
        if (out_data.vertex_index !== want.vertex_index) begin
          $error("vertex_index expected %0d actual %0d", want.vertex_index,
                 out_data.vertex_index);
          errors++;
        end
        if (out_data.last_vertex !== want.last_vertex) begin
          $error("last_vertex expected %0d actual %0d", want.last_vertex,
                 out_data.last_vertex);
          errors++;
        end
      end
    end
  end

  function automatic bit furthest_outer(int a, int b, output int pick);
    longint dx, dy, dlen2, bound, vx, vy, c, mag, most;
    bit     found;
    dx    = longint'(set_x[b]) - longint'(set_x[a]);
    dy    = longint'(set_y[b]) - longint'(set_y[a]);
    dlen2 = dx * dx + dy * dy;
    bound = longint'(tolerance) * longint'(tolerance) * dlen2;
    found = 1'b0;
    most  = 0;
    pick  = 0;
    for (int i = 0; i < set_count; i++) begin
      vx = longint'(set_x[i]) - longint'(set_x[a]);
      vy = longint'(set_y[i]) - longint'(set_y[a]);
      c  = dx * vy - dy * vx;
      if (c < 0) begin
        mag = -c;
        if ((mag >= (longint'(1) << 25)) || (mag * mag > bound)) begin
          if (!found || c < most) begin
            most  = c;
            pick  = i;
            found = 1'b1;
          end
        end
      end
    end
    return found;
  endfunction

  task automatic compute_hull();
    int             lft, rgt, pos, nxt, pick;
    chi_pkg::hull_t v;
    lft = 0;
    rgt = 0;
    for (int i = 1; i < set_count; i++) begin
      if (set_x[i] < set_x[lft]) lft = i;
      if (set_x[i] > set_x[rgt]) rgt = i;
    end
    order[0]  = lft;
    order[1]  = rgt;
    order_len = 2;
    pos       = 0;
    while (pos < order_len) begin
      nxt = (pos + 1) % order_len;
      if (order_len < LIST_CAP && furthest_outer(order[pos], order[nxt], pick)) begin
        for (int k = order_len; k > nxt; k--) order[k] = order[k-1];
        order[nxt] = pick;
        order_len++;
        pos = 0;
      end else begin
        pos++;
      end
    end
    for (int k = 0; k < order_len; k++) begin
      v.hull_x       = set_x[order[k]];
      v.hull_y       = set_y[order[k]];
      v.vertex_index = 6'(k);
      v.last_vertex  = (k + 1 == order_len);
      pending_vertices = {pending_vertices, v};
    end
    set_count = 0;
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    int gap;
    in_valid           <= 1'b1;
    in_data.point_x    <= x;
    in_data.point_y    <= y;
    in_data.last_point <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (set_count < NPTS) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
    end
    if (last) compute_hull();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [7:0] t);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tolerance = t;
  endtask

  function automatic logic signed [15:0] rand_coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($signed($urandom_range(0, 64)) - 32);
  endfunction

  task automatic send_random_set(int n, bit wide);
    for (int i = 0; i < n; i++) send_point(rand_coord(wide), rand_coord(wide), i == n - 1);
  endtask

  task automatic test_single_point();
    send_point(16'sh7fff, -16'sd32768, 1'b1);
  endtask

  task automatic test_one_column();
    send_point(16'sd5, 16'sd9, 1'b0);
    send_point(16'sd5, -16'sd4, 1'b0);
    send_point(16'sd5, 16'sd100, 1'b1);
  endtask

  task automatic test_extreme_corners();
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 1'b1);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(8'd0);
    send_point(-16'sd10, 16'sd0, 1'b0);
    send_point(16'sd10, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd1, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b1);
    write_tolerance(8'd255);
    send_point(-16'sd20000, 16'sd0, 1'b0);
    send_point(16'sd20000, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd200, 1'b0);
    send_point(16'sd0, 16'sd300, 1'b1);
    write_tolerance(8'd1);
  endtask

  task automatic test_overflow();
    send_random_set(NPTS + 2, 1'b1);
  endtask

  task automatic test_full_convex();
    write_tolerance(8'd0);
    for (int i = 0; i < NPTS; i++)
      send_point(16'(i * 64 - 1024), 16'((i - 16) * (i - 16) * 40 - 5000), i == NPTS - 1);
  endtask

  // receiver held off while the sender keeps offering a second set
  task automatic test_output_backpressure();
    wait_drained();
    hold_req = 2000;
    send_random_set(6, 1'b0);
    send_random_set(5, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int n;
    while (items_sent < 250) begin
      if ($urandom_range(0, 9) == 0) write_tolerance(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 29) == 0) n = $urandom_range(20, NPTS + 3);
      else n = $urandom_range(1, 8);
      send_random_set(n, $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    errors      = 0;
    cycles      = 0;
    burst_left  = 0;
    hold_req    = 0;
    hold_cnt    = 0;
    calm_phase  = 1'b0;
    items_sent  = 0;
    set_count   = 0;
    tolerance   = chi_pkg::TOL_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_point();
    test_one_column();
    test_extreme_corners();
    test_tolerance_extremes();
    test_overflow();
    test_full_convex();
    write_tolerance(8'd1);
    test_output_backpressure();
    test_random_sets();

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/chi_pkg.sv
hw/rtl/chi_hull_cell.sv
hw/rtl/chi_edge_unit.sv
hw/rtl/convex_hull_insertion.sv
tb/tb.sv
